// ===== rtl/rope_pkg.sv =====
package rope_pkg;

	localparam int MaxPairsDef = 64;
	localparam int PosBitsDef = 20;
	localparam int CordicSteps = 30;
	localparam int IdxW = 6;
	localparam int PosW = 20;
	localparam int ValW = 32;
	localparam int FreqW = 32;
	localparam int CordW = 34;
	localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_ROTATE = 1'b1;

	function automatic logic signed [CordW-1:0] atan_turns(input int i);
		logic signed [CordW-1:0] r;
		case (i)
			0: r = 34'sh020000000;
			1: r = 34'sh012E4051E;
			2: r = 34'sh009FB385B;
			3: r = 34'sh0051111D4;
			4: r = 34'sh0028B0D43;
			5: r = 34'sh00145D7E1;
			6: r = 34'sh000A2F61E;
			7: r = 34'sh000517C55;
			8: r = 34'sh00028BE53;
			9: r = 34'sh000145F2F;
			10: r = 34'sh0000A2F98;
			11: r = 34'sh0000517CC;
			12: r = 34'sh000028BE6;
			13: r = 34'sh0000145F3;
			14: r = 34'sh000000A2FA;
			15: r = 34'sh00000517D;
			16: r = 34'sh0000028BE;
			17: r = 34'sh00000145F;
			18: r = 34'sh000000A30;
			19: r = 34'sh000000518;
			20: r = 34'sh00000028C;
			21: r = 34'sh000000146;
			22: r = 34'sh0000000A3;
			23: r = 34'sh000000051;
			24: r = 34'sh000000029;
			25: r = 34'sh000000014;
			26: r = 34'sh00000000A;
			27: r = 34'sh000000005;
			28: r = 34'sh000000003;
			29: r = 34'sh000000001;
			default: r = '0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [ValW-1:0] a;
		logic signed [ValW-1:0] b;
	} pair_t;

endpackage

// ===== rtl/rope_freq_mem.sv =====
module rope_freq_mem #(
	parameter int MAX_PAIRS = rope_pkg::MaxPairsDef
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(MAX_PAIRS > 1 ? MAX_PAIRS : 2)-1:0] wr_addr,
	input  logic [rope_pkg::FreqW-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [$clog2(MAX_PAIRS > 1 ? MAX_PAIRS : 2)-1:0] rd_addr,
	output logic [rope_pkg::FreqW-1:0]  rd_data
);
	import rope_pkg::*;

	logic [FreqW-1:0] mem_q [MAX_PAIRS];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en) begin
			// write in the same cycle as a read of the same entry: forward new data
			if (wr_en && wr_addr == rd_addr)
				rd_data <= wr_data;
			else
				rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== rtl/rope_cordic.sv =====
// One CORDIC iteration per stage; payload rides along.
module rope_cordic #(
	parameter int PW = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [23:0]                 in_phase,
	input  logic [PW-1:0]               in_pay,
	output logic                        out_vld,
	output logic signed [rope_pkg::CordW-1:0] out_cos,
	output logic signed [rope_pkg::CordW-1:0] out_sin,
	output logic [PW-1:0]               out_pay
);
	import rope_pkg::*;

	localparam int N = CordicSteps;

	logic signed [CordW-1:0] x_q [1:N];
	logic signed [CordW-1:0] y_q [1:N];
	logic signed [CordW-1:0] z_q [1:N];
	logic [1:0]              quad_q [1:N];
	logic [PW-1:0]           pay_q [1:N];
	logic                    vld_q [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [CordW-1:0] xi, yi, zi;
		logic [1:0]              qi;
		logic [PW-1:0]           pi;
		logic                    vi;

		if (i == 0) begin : g_first
			assign xi = CordicGain;
			assign yi = '0;
			assign zi = $signed({2'b00, in_phase[21:0], 10'b0}) >>> 2;
			assign qi = in_phase[23:22];
			assign pi = in_pay;
			assign vi = in_vld;
		end else begin : g_next
			assign xi = x_q[i];
			assign yi = y_q[i];
			assign zi = z_q[i];
			assign qi = quad_q[i];
			assign pi = pay_q[i];
			assign vi = vld_q[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[i+1] <= 1'b0;
			else if (en)
				vld_q[i+1] <= vi;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[CordW-1]) begin
					x_q[i+1] <= xi - (yi >>> i);
					y_q[i+1] <= yi + (xi >>> i);
					z_q[i+1] <= zi - atan_turns(i);
				end else begin
					x_q[i+1] <= xi + (yi >>> i);
					y_q[i+1] <= yi - (xi >>> i);
					z_q[i+1] <= zi + atan_turns(i);
				end
				quad_q[i+1] <= qi;
				pay_q[i+1] <= pi;
			end
		end
	end

	always_comb begin
		case (quad_q[N])
			2'd0: begin out_cos = x_q[N]; out_sin = y_q[N]; end
			2'd1: begin out_cos = -y_q[N]; out_sin = x_q[N]; end
			2'd2: begin out_cos = -x_q[N]; out_sin = -y_q[N]; end
			default: begin out_cos = y_q[N]; out_sin = -x_q[N]; end
		endcase
	end
	assign out_vld = vld_q[N];
	assign out_pay = pay_q[N];
endmodule

// ===== rtl/rotary_position_embedding_core.sv =====
// Rotary position embedding. Load transactions (tuser=0) write one frequency
// entry and give no result; rotate transactions (tuser=1) give one rotated pair.
// One transaction per cycle is taken; the whole pipeline advances only while the
// output is free or taken (single global enable). A rotate passes through the
// table read, phase multiply (two partial products), phase sum, 30 CORDIC
// stages, product stage and round/saturate stage. A rotate that follows a load
// to the same entry in the next cycle reads the newly loaded value.
module rotary_position_embedding_core #(
	parameter int MAX_PAIRS = rope_pkg::MaxPairsDef,
	parameter int POS_BITS = rope_pkg::PosBitsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pair_index[5:0], freq_turns[37:6], position[57:38], first_value[89:58],
	// second_value[121:90], zero fill to 127
	input  logic [127:0] s_tdata,
	input  logic         s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	// rotated_first[31:0], rotated_second[63:32]
	output logic [63:0]  m_tdata
);
	import rope_pkg::*;

	localparam int AW = $clog2(MAX_PAIRS > 1 ? MAX_PAIRS : 2);
	localparam int PB = (POS_BITS < PosW) ? POS_BITS : PosW;
	localparam int PW = 2 * ValW;

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic acc;
	assign acc = s_tvalid && s_tready;

	// index wraps modulo the table depth; constant lookup over all index codes
	function automatic logic [AW-1:0] wrap_idx(input logic [IdxW-1:0] i);
		logic [AW-1:0] r;
		r = '0;
		for (int k = 0; k < (1 << IdxW); k++)
			if (i == IdxW'(k))
				r = AW'(k % MAX_PAIRS);
		return r;
	endfunction

	logic [IdxW-1:0] idx_in;
	logic [AW-1:0] addr;
	logic [PosW-1:0] pos_in;
	assign idx_in = s_tdata[5:0];
	assign addr = wrap_idx(idx_in);
	assign pos_in = s_tdata[57:38] & PosW'((64'd1 << PB) - 64'd1);

	logic [FreqW-1:0] freq_s1;
	rope_freq_mem #(.MAX_PAIRS(MAX_PAIRS)) u_mem (
		.clk(clk),
		.wr_en(acc && s_tuser == REQ_LOAD),
		.wr_addr(addr),
		.wr_data(s_tdata[37:6]),
		.rd_en(en),
		.rd_addr(addr),
		.rd_data(freq_s1)
	);

	logic vld_s1, vld_s2, vld_s3;
	logic [PosW-1:0] pos_s1;
	pair_t pay_s1, pay_s2, pay_s3;
	logic [35:0] plo_s2, phi_s2;
	logic [23:0] phase_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc && s_tuser == REQ_ROTATE;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos_in;
			pay_s1 <= {s_tdata[89:58], s_tdata[121:90]};
			// only bits 4..27 of the product are needed
			plo_s2 <= 36'(freq_s1[15:0] * pos_s1);
			phi_s2 <= 36'(freq_s1[31:16] * pos_s1);
			pay_s2 <= pay_s1;
			phase_s3 <= 24'((plo_s2 + {phi_s2[19:0], 16'b0}) >> 4);
			pay_s3 <= pay_s2;
		end
	end

	logic cv;
	logic signed [CordW-1:0] cosv, sinv;
	pair_t cp;
	rope_cordic #(.PW(PW)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(vld_s3), .in_phase(phase_s3), .in_pay(pay_s3),
		.out_vld(cv), .out_cos(cosv), .out_sin(sinv), .out_pay(cp)
	);

	logic vld_s4;
	logic signed [65:0] ac_s4, bs_s4, as_s4, bc_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= cv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ac_s4 <= 66'(cp.a * cosv);
			bs_s4 <= 66'(cp.b * sinv);
			as_s4 <= 66'(cp.a * sinv);
			bc_s4 <= 66'(cp.b * cosv);
		end
	end

	function automatic logic [ValW-1:0] rnd_sat(input logic signed [66:0] v);
		logic signed [66:0] r;
		r = (v + 67'sd536870912) >>> 30;
		if (r > 67'sd2147483647) return 32'h7FFFFFFF;
		if (r < -67'sd2147483648) return 32'h80000000;
		return r[31:0];
	endfunction

	logic [ValW-1:0] r0_q, r1_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= vld_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r0_q <= rnd_sat(67'(ac_s4) - 67'(bs_s4));
			r1_q <= rnd_sat(67'(as_s4) + 67'(bc_s4));
		end
	end
	assign m_tdata = {r1_q, r0_q};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
	a_load_nores: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser == REQ_LOAD |=> !vld_s1)
		else $error("load made a result");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("stall with empty output");
endmodule
